[rtl/core/dics_pkg.sv]
// shared types, constants and codes for the density inverse cdf sampler
package dics_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH     = 256;
    localparam int DEF_MAX_HEIGHT    = 256;
    localparam int DEF_FRACTION_BITS = 16;

    // largest density of one pixel, white maps to zero
    localparam int DENSITY_MAX = 255;

    // fixed field widths
    localparam int PIXEL_W     = 8;
    localparam int UNIFORM_W   = 16;
    localparam int COORD_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 9;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_TOTAL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    typedef struct packed {
        logic                 op;
        logic [PIXEL_W-1:0]   pixel_value;
        logic [UNIFORM_W-1:0] uniform_across;
        logic [UNIFORM_W-1:0] uniform_down;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]  sample_x;
        logic [COORD_W-1:0]  sample_y;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    // control from the sequencer to the search unit
    typedef struct packed {
        logic start;
        logic step;
    } srch_ctrl_t;

endpackage

[rtl/core/dics_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
module dics_ram #(
    parameter int AW = 8,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [0:(1 << AW)-1];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/dics_search.sv]
// binary search step unit, one halving of the interval per memory read
module dics_search #(
    parameter int IW = 8,
    parameter int VW = 24,
    parameter int FB = 16,
    parameter int TW = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dics_pkg::srch_ctrl_t ctrl,
    input  logic [IW-1:0]        start_hi,
    input  logic [VW-1:0]        value,
    input  logic [TW-1:0]        target,
    output logic [IW-1:0]        idx_next,
    output logic [IW-1:0]        res_next,
    output logic                 more
);
    import dics_pkg::*;

    // compare width covers both the scaled value and the target
    localparam int KW = VW + ((FB > TW - VW) ? FB : TW - VW);

    logic [IW-1:0] lo_reg;
    logic [IW-1:0] lo_next;
    logic [IW-1:0] hi_reg;
    logic [IW-1:0] hi_next;
    logic [IW-1:0] mid_reg;
    logic [IW-1:0] mid_next;
    logic [IW:0]   span_sum;
    logic [KW-1:0] scaled;
    logic          reach;

    always_comb
    begin
        scaled  = KW'(value) << FB;
        reach   = (scaled >= KW'(target));
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.start)
        begin
            lo_next = '0;
            hi_next = start_hi;
        end
        else if (ctrl.step)
        begin
            if (reach)
            begin
                hi_next = mid_reg;
            end
            else
            begin
                lo_next = mid_reg + 1'b1;
            end
        end
        span_sum = {1'b0, lo_next} + {1'b0, hi_next};
        mid_next = span_sum[IW:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg  <= '0;
            hi_reg  <= '0;
            mid_reg <= '0;
        end
        else
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
    end

    assign idx_next = mid_next;
    assign res_next = lo_next;
    assign more     = (lo_next < hi_next);

endmodule

[rtl/core/density_inverse_cdf_sampler_core.sv]
// top level of the density inverse cdf sampler: sequencer, stores and output register
//
//  channel  | handshake            | payload                                   | direction
//  ---------+----------------------+-------------------------------------------+----------
//  item     | item_valid/stall     | op, pixel_value, uniform_across/down      | in
//  result   | result_valid/stall   | sample_x, sample_y, status                | out
//  cfg      | cfg_valid/ready      | cfg_index, cfg_data (image_width/height)  | in
//
//  a load transaction reads the sum above, then adds and writes back
//  a sample transaction is paced by the two binary searches,
//  each one read of a store per cycle through a shared unit
//  a sample that finds the image incomplete finishes without a search
//  reset clears the load position and the ready flag, both stores need no clearing pass
//  a finished result waits in the output register while the next transaction is taken
module density_inverse_cdf_sampler_core #(
    parameter int MAX_WIDTH     = dics_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = dics_pkg::DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = dics_pkg::DEF_FRACTION_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  dics_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output dics_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dics_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dics_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dics_pkg::*;

    // column and row index widths
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int IW = (XW > YW) ? XW : YW;
    // running column sum and prefix widths
    localparam int SW = $clog2(DENSITY_MAX * MAX_HEIGHT + 1);
    localparam int PW = $clog2(DENSITY_MAX * MAX_HEIGHT * MAX_WIDTH + 1);
    // product of a fraction and a total
    localparam int TW = UNIFORM_W + PW;
    // only the low fraction bits of the uniform inputs count
    localparam logic [UNIFORM_W-1:0] FMASK = (FRACTION_BITS >= UNIFORM_W) ?
        '1 : UNIFORM_W'((1 << FRACTION_BITS) - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LWR   = 3'd1;
    localparam logic [2:0] S_TOT   = 3'd2;
    localparam logic [2:0] S_CSRCH = 3'd3;
    localparam logic [2:0] S_RTOT  = 3'd4;
    localparam logic [2:0] S_RSRCH = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] width_next;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [CFG_DATA_W-1:0] height_next;
    logic [XW-1:0]         col_reg;
    logic [XW-1:0]         col_next;
    logic [YW-1:0]         row_reg;
    logic [YW-1:0]         row_next;
    logic                  ready_reg;
    logic                  ready_next;
    logic                  result_valid_reg;
    logic                  result_valid_next;

    // payload registers
    logic [PIXEL_W-1:0]    pix_reg;
    logic [PIXEL_W-1:0]    pix_next;
    logic [UNIFORM_W-1:0]  ua_reg;
    logic [UNIFORM_W-1:0]  ua_next;
    logic [UNIFORM_W-1:0]  ud_reg;
    logic [UNIFORM_W-1:0]  ud_next;
    logic [TW-1:0]         target_reg;
    logic [TW-1:0]         target_next;
    logic [PW-1:0]         pref_run_reg;
    logic [PW-1:0]         pref_run_next;
    logic [XW-1:0]         sx_reg;
    logic [XW-1:0]         sx_next;
    logic [YW-1:0]         sy_reg;
    logic [YW-1:0]         sy_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    out_item_t             result_reg;
    out_item_t             result_next;

    // effective last column and row after clamping the registers
    logic [XW-1:0]         wlast;
    logic [YW-1:0]         hlast;

    // store ports
    logic                  sums_wr_en;
    logic [XW+YW-1:0]      sums_wr_addr;
    logic [SW-1:0]         sums_wr_data;
    logic                  sums_rd_en;
    logic [XW+YW-1:0]      sums_rd_addr;
    logic [SW-1:0]         sums_rd_data;
    logic                  pref_wr_en;
    logic [XW-1:0]         pref_wr_addr;
    logic [PW-1:0]         pref_wr_data;
    logic                  pref_rd_en;
    logic [XW-1:0]         pref_rd_addr;
    logic [PW-1:0]         pref_rd_data;

    // search unit
    srch_ctrl_t            srch_ctrl;
    logic [IW-1:0]         srch_hi;
    logic [PW-1:0]         srch_value;
    logic [IW-1:0]         srch_idx;
    logic [IW-1:0]         srch_res;
    logic                  srch_more;

    logic [SW-1:0]         load_sum;
    logic [PW-1:0]         load_pref;

    // zero acts as one, anything above the maximum acts as the maximum
    always_comb
    begin
        if (width_reg == '0)
        begin
            wlast = '0;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            wlast = XW'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast = XW'(width_reg - 1'b1);
        end
        if (height_reg == '0)
        begin
            hlast = '0;
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            hlast = YW'(MAX_HEIGHT - 1);
        end
        else
        begin
            hlast = YW'(height_reg - 1'b1);
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE) && !item_valid;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        ready_next        = ready_reg;
        result_valid_next = result_valid_reg;
        pix_next          = pix_reg;
        ua_next           = ua_reg;
        ud_next           = ud_reg;
        target_next       = target_reg;
        pref_run_next     = pref_run_reg;
        sx_next           = sx_reg;
        sy_next           = sy_reg;
        status_next       = status_reg;
        result_next       = result_reg;

        sums_wr_en   = 1'b0;
        sums_wr_addr = '0;
        sums_wr_data = '0;
        sums_rd_en   = 1'b0;
        sums_rd_addr = '0;
        pref_wr_en   = 1'b0;
        pref_wr_addr = '0;
        pref_wr_data = '0;
        pref_rd_en   = 1'b0;
        pref_rd_addr = '0;
        srch_ctrl    = '0;
        srch_hi      = '0;
        srch_value   = '0;
        load_sum     = '0;
        load_pref    = '0;

        // output register drains independently of the sequencer
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    unique case (cfg_index)
                        REG_IMAGE_WIDTH:
                        begin
                            width_next = cfg_data;
                            col_next   = '0;
                            row_next   = '0;
                            ready_next = 1'b0;
                        end
                        REG_IMAGE_HEIGHT:
                        begin
                            height_next = cfg_data;
                            col_next    = '0;
                            row_next    = '0;
                            ready_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (item_valid)
                begin
                    if (item.op == OP_LOAD)
                    begin
                        pix_next     = PIXEL_W'(DENSITY_MAX) - item.pixel_value;
                        // sum of the same column one row up
                        sums_rd_en   = 1'b1;
                        sums_rd_addr = {row_reg - 1'b1, col_reg};
                        // first pixel of a new image drops the old one
                        if (col_reg == '0 && row_reg == '0)
                        begin
                            ready_next = 1'b0;
                        end
                        state_next = S_LWR;
                    end
                    else
                    begin
                        ua_next = item.uniform_across & FMASK;
                        ud_next = item.uniform_down & FMASK;
                        if (!ready_reg)
                        begin
                            status_next = STATUS_NOT_LOADED;
                            sx_next     = '0;
                            sy_next     = '0;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            // grand total sits in the last column's prefix
                            pref_rd_en   = 1'b1;
                            pref_rd_addr = wlast;
                            state_next   = S_TOT;
                        end
                    end
                end
            end
            S_LWR:
            begin
                if (row_reg == '0)
                begin
                    load_sum = SW'(pix_reg);
                end
                else
                begin
                    load_sum = sums_rd_data + SW'(pix_reg);
                end
                sums_wr_en   = 1'b1;
                sums_wr_addr = {row_reg, col_reg};
                sums_wr_data = load_sum;
                // bottom row: extend the running prefix across columns
                if (row_reg == hlast)
                begin
                    load_pref     = ((col_reg == '0) ? '0 : pref_run_reg) + PW'(load_sum);
                    pref_wr_en    = 1'b1;
                    pref_wr_addr  = col_reg;
                    pref_wr_data  = load_pref;
                    pref_run_next = load_pref;
                end
                if (col_reg == wlast)
                begin
                    col_next = '0;
                    if (row_reg == hlast)
                    begin
                        row_next   = '0;
                        ready_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            S_TOT:
            begin
                if (pref_rd_data == '0)
                begin
                    status_next = STATUS_ZERO_TOTAL;
                    sx_next     = '0;
                    sy_next     = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    target_next     = TW'(ua_reg) * TW'(pref_rd_data);
                    srch_ctrl.start = 1'b1;
                    srch_hi         = IW'(wlast);
                    if (srch_more)
                    begin
                        pref_rd_en   = 1'b1;
                        pref_rd_addr = XW'(srch_idx);
                        state_next   = S_CSRCH;
                    end
                    else
                    begin
                        // single column, fetch its total
                        sx_next      = XW'(srch_res);
                        sums_rd_en   = 1'b1;
                        sums_rd_addr = {hlast, XW'(srch_res)};
                        state_next   = S_RTOT;
                    end
                end
            end
            S_CSRCH:
            begin
                srch_ctrl.step = 1'b1;
                srch_value     = pref_rd_data;
                if (srch_more)
                begin
                    pref_rd_en   = 1'b1;
                    pref_rd_addr = XW'(srch_idx);
                end
                else
                begin
                    sx_next      = XW'(srch_res);
                    sums_rd_en   = 1'b1;
                    sums_rd_addr = {hlast, XW'(srch_res)};
                    state_next   = S_RTOT;
                end
            end
            S_RTOT:
            begin
                target_next     = TW'(ud_reg) * TW'(sums_rd_data);
                srch_ctrl.start = 1'b1;
                srch_hi         = IW'(hlast);
                if (srch_more)
                begin
                    sums_rd_en   = 1'b1;
                    sums_rd_addr = {YW'(srch_idx), sx_reg};
                    state_next   = S_RSRCH;
                end
                else
                begin
                    sy_next     = YW'(srch_res);
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                end
            end
            S_RSRCH:
            begin
                srch_ctrl.step = 1'b1;
                srch_value     = PW'(sums_rd_data);
                if (srch_more)
                begin
                    sums_rd_en   = 1'b1;
                    sums_rd_addr = {YW'(srch_idx), sx_reg};
                end
                else
                begin
                    sy_next     = YW'(srch_res);
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand over once the output register is free or draining
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next    = 1'b1;
                    result_next.sample_x = COORD_W'(sx_reg);
                    result_next.sample_y = COORD_W'(sy_reg);
                    result_next.status   = status_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            width_reg        <= CFG_DATA_W'(256);
            height_reg       <= CFG_DATA_W'(256);
            col_reg          <= '0;
            row_reg          <= '0;
            ready_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            ready_reg        <= ready_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        ua_reg       <= ua_next;
        ud_reg       <= ud_next;
        target_reg   <= target_next;
        pref_run_reg <= pref_run_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        status_reg   <= status_next;
        result_reg   <= result_next;
    end

    // running sums down each column, addressed by row then column
    dics_ram #(
        .AW (XW + YW),
        .DW (SW)
    ) u_sums (
        .clk     (clk),
        .wr_en   (sums_wr_en),
        .wr_addr (sums_wr_addr),
        .wr_data (sums_wr_data),
        .rd_en   (sums_rd_en),
        .rd_addr (sums_rd_addr),
        .rd_data (sums_rd_data)
    );

    // prefix of the column totals across the image
    dics_ram #(
        .AW (XW),
        .DW (PW)
    ) u_prefix (
        .clk     (clk),
        .wr_en   (pref_wr_en),
        .wr_addr (pref_wr_addr),
        .wr_data (pref_wr_data),
        .rd_en   (pref_rd_en),
        .rd_addr (pref_rd_addr),
        .rd_data (pref_rd_data)
    );

    // shared by the column search and the row search
    dics_search #(
        .IW (IW),
        .VW (PW),
        .FB (FRACTION_BITS),
        .TW (TW)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (srch_ctrl),
        .start_hi (srch_hi),
        .value    (srch_value),
        .target   (target_reg),
        .idx_next (srch_idx),
        .res_next (srch_res),
        .more     (srch_more)
    );

endmodule

[tb/sv/tb_density_inverse_cdf_sampler_core.sv]
// self-checking testbench for the density inverse cdf sampler core
module tb_density_inverse_cdf_sampler_core;

    import dics_pkg::*;

    // clock and run limits
    localparam int CLK_PERIOD    = 8;
    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_ITEMS  = 800;

    // geometry of the stores, matching the default build of the block
    localparam int MAXW      = DEF_MAX_WIDTH;
    localparam int MAXH      = DEF_MAX_HEIGHT;
    localparam int FRAC_BITS = DEF_FRACTION_BITS;
    localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

    // pixel content styles for generated images
    typedef enum int {
        SHADE_RANDOM,
        SHADE_WHITE,
        SHADE_BLACK,
        SHADE_SPARSE,
        SHADE_STRIPED
    } shade_t;

    // every input starts at a known value, reset held from time zero
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    in_item_t               item_bus     = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    out_item_t              result_bus;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // transactions waiting to be offered, and coordinates still owed by the block
    in_item_t  queued_requests [$];
    out_item_t owed_coords [$];
    int unsigned queued_count   = 0;
    int unsigned mismatch_count = 0;

    // idling as percentages of cycles, changed per phase
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;

    // effective image geometry as seen by the stimulus
    int unsigned geo_w = MAXW;
    int unsigned geo_h = MAXH;

    // predictor state: column sums down each column, prefix of column totals
    logic [15:0] colsum_mem [0:MAXW*MAXH-1];
    logic [23:0] prefix_mem [0:MAXW-1];
    int unsigned pixel_pos  = 0;
    bit          image_full = 1'b0;
    logic [8:0]  width_reg  = 9'd256;
    logic [8:0]  height_reg = 9'd256;

    density_inverse_cdf_sampler_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_bus),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #(CLK_PERIOD/2) clk = 1'b1;
        #(CLK_PERIOD/2) clk = 1'b0;
    end

    // zero acts as one, anything past the store size acts as the store size
    function automatic int unsigned clamp_dim(input logic [8:0] v, input int unsigned lim);
        if (v == 9'd0)
            return 1;
        if (v > lim)
            return lim;
        return 32'(v);
    endfunction

    // advance the predictor by one accepted transaction; a draw owes one coordinate
    function automatic void track_item(input in_item_t it);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic [7:0]  dens;
        logic [15:0] run;
        logic [23:0] total;
        logic [63:0] goal;
        out_item_t   want;
        w = clamp_dim(width_reg, MAXW);
        h = clamp_dim(height_reg, MAXH);
        if (it.op == OP_LOAD)
        begin
            // a load after a complete image begins the next one
            if (pixel_pos >= w * h)
                pixel_pos = 0;
            if (pixel_pos == 0)
                image_full = 1'b0;
            x    = pixel_pos % w;
            y    = pixel_pos / w;
            dens = 8'(DENSITY_MAX - int'(it.pixel_value));
            run  = (y == 0) ? 16'(dens) : colsum_mem[(y - 1) * MAXW + x] + 16'(dens);
            colsum_mem[y * MAXW + x] = run;
            if (y == h - 1)
                prefix_mem[x] = ((x == 0) ? 24'd0 : prefix_mem[x - 1]) + 24'(run);
            pixel_pos++;
            if (pixel_pos >= w * h)
            begin
                pixel_pos  = 0;
                image_full = 1'b1;
            end
        end
        else
        begin
            want = '0;
            if (!image_full)
                want.status = STATUS_NOT_LOADED;
            else if (prefix_mem[w - 1] == 24'd0)
                want.status = STATUS_ZERO_TOTAL;
            else
            begin
                // first column whose prefix reaches the scaled target
                total = prefix_mem[w - 1];
                goal  = (64'(it.uniform_across) & FRAC_MASK) * 64'(total);
                lo = 0;
                hi = w - 1;
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if ((64'(prefix_mem[mid]) << FRAC_BITS) >= goal)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                x = lo;
                // first row of that column whose running sum reaches the target
                goal = (64'(it.uniform_down) & FRAC_MASK) * 64'(colsum_mem[(h - 1) * MAXW + x]);
                lo = 0;
                hi = h - 1;
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if ((64'(colsum_mem[mid * MAXW + x]) << FRAC_BITS) >= goal)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                want.status   = STATUS_OK;
                want.sample_x = x[7:0];
                want.sample_y = lo[7:0];
            end
            owed_coords = {owed_coords, want};
        end
    endfunction

    // driver: holds a transaction until accepted, then offers the next or idles
    always @(posedge clk)
    begin : item_driver
        logic taken;
        taken = item_valid && !item_stall;
        if (taken)
            track_item(item_bus);
        if (!item_valid || taken)
        begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                item_bus   <= queued_requests.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // monitor: compares each accepted coordinate with the oldest one owed
    always @(posedge clk)
    begin : result_monitor
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (owed_coords.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: x=%0d y=%0d status=%0d",
                             result_bus.sample_x, result_bus.sample_y, result_bus.status);
            end
            else
            begin
                want = owed_coords.pop_front();
                if (result_bus.sample_x !== want.sample_x ||
                    result_bus.sample_y !== want.sample_y ||
                    result_bus.status   !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: want x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                                 want.sample_x, want.sample_y, want.status,
                                 result_bus.sample_x, result_bus.sample_y, result_bus.status);
                end
            end
        end
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // unused fields of each transaction carry random bits
    function automatic void queue_load(input logic [7:0] v);
        in_item_t r;
        r.op             = OP_LOAD;
        r.pixel_value    = v;
        r.uniform_across = 16'($urandom);
        r.uniform_down   = 16'($urandom);
        queued_requests = {queued_requests, r};
        queued_count++;
    endfunction

    function automatic void queue_sample(input logic [15:0] ua, input logic [15:0] ud);
        in_item_t r;
        r.op             = OP_SAMPLE;
        r.pixel_value    = 8'($urandom);
        r.uniform_across = ua;
        r.uniform_down   = ud;
        queued_requests = {queued_requests, r};
        queued_count++;
    endfunction

    // fractions biased towards both ends of the range
    function automatic logic [15:0] pick_fraction();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    // pixels first..first+count-1 of the raster, styled
    function automatic void queue_pixels(input shade_t style, input int unsigned first,
                                         input int unsigned count);
        int unsigned stripe;
        int unsigned i;
        logic [7:0]  v;
        stripe = $urandom_range(2);
        for (i = first; i < first + count; i++)
        begin
            case (style)
                SHADE_WHITE:   v = 8'd255;
                SHADE_BLACK:   v = 8'd0;
                SHADE_SPARSE:  v = ($urandom_range(7) == 0) ? 8'($urandom_range(254)) : 8'd255;
                SHADE_STRIPED: v = ((i % geo_w) % 3 == stripe) ? 8'd255 : 8'($urandom);
                default:       v = 8'($urandom);
            endcase
            queue_load(v);
        end
    endfunction

    // wait until nothing is queued, offered or owed, then let the block go quiet
    task automatic settle();
        while (queued_requests.size() != 0 || item_valid || owed_coords.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; a write restarts the image load in the predictor too
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [8:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val;
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = val;
        pixel_pos  = 0;
        image_full = 1'b0;
    endtask

    task automatic set_size(input logic [8:0] wv, input logic [8:0] hv, input bit width_only);
        settle();
        write_reg(REG_IMAGE_WIDTH, wv);
        geo_w = clamp_dim(wv, MAXW);
        if (!width_only)
        begin
            write_reg(REG_IMAGE_HEIGHT, hv);
            geo_h = clamp_dim(hv, MAXH);
        end
    endtask

    initial
    begin
        int unsigned kind;
        int unsigned n;
        int unsigned extra;
        int unsigned start_count;
        int unsigned phase;
        int unsigned r;
        logic [8:0]  wv;
        logic [8:0]  hv;
        shade_t      style;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // draws before anything is loaded and during a partial load at the reset geometry
        queue_sample(16'h0000, 16'h0000);
        queue_pixels(SHADE_SPARSE, 0, MAXW);
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF);

        // zero-valued registers act as a single pixel: black then all white
        set_size(9'd0, 9'd0, 1'b0);
        queue_load(8'd0);
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF);
        queue_load(8'd255);
        queue_sample(16'h1234, 16'hFEDC);

        // 3 x 2 with a white first column, only reachable with a zero fraction
        set_size(9'd3, 9'd2, 1'b0);
        queue_load(8'd255);
        queue_load(8'd0);
        queue_load(8'd128);
        queue_load(8'd255);
        queue_load(8'd200);
        queue_load(8'd0);
        queue_sample(16'h0000, 16'hFFFF);
        queue_sample(16'hFFFF, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF);
        queue_sample(16'h8000, 16'h8000);
        // loads past a full image start over, so the image is incomplete again
        queue_load(8'd17);
        queue_load(8'd99);
        queue_sample(16'h4000, 16'h4000);

        // register write in the middle of a load restarts it
        set_size(9'd2, 9'd2, 1'b0);
        queue_pixels(SHADE_RANDOM, 0, 4);
        queue_sample(pick_fraction(), pick_fraction());

        // extremes of geometry: widest single row, tallest single column, explicit 256
        set_size(9'd511, 9'd1, 1'b0);
        queue_pixels(SHADE_STRIPED, 0, geo_w * geo_h);
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF);
        repeat (4)
            queue_sample(pick_fraction(), pick_fraction());
        set_size(9'd1, 9'd300, 1'b0);
        queue_pixels(SHADE_BLACK, 0, geo_w * geo_h);
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF);
        repeat (4)
            queue_sample(pick_fraction(), pick_fraction());
        set_size(9'd256, 9'd2, 1'b0);
        queue_pixels(SHADE_SPARSE, 0, geo_w * geo_h);
        queue_sample(16'hFFFF, 16'hFFFF);
        repeat (4)
            queue_sample(pick_fraction(), pick_fraction());

        // random sets, walking through the idling phases by items queued
        start_count = queued_count;
        while (queued_count - start_count < RANDOM_ITEMS)
        begin
            phase = (queued_count - start_count) * 4 / RANDOM_ITEMS;
            case (phase)
                0:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct   = 75;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 75;
                end
                default:
                begin
                    send_gap_pct   = 24;
                    recv_stall_pct = 24;
                end
            endcase

            kind  = $urandom_range(9);
            style = shade_t'($urandom_range(4));

            // geometry: mostly small, now and then an extreme
            if (kind != 9)
            begin
                r = $urandom_range(29);
                if (r == 0)
                begin
                    wv = 9'($urandom_range(257, 511));
                    hv = 9'($urandom_range(1, 2));
                end
                else if (r == 1)
                begin
                    wv = 9'd1;
                    hv = $urandom_range(1) ? 9'd256 : 9'd0;
                end
                else
                begin
                    wv = 9'($urandom_range(1, 12));
                    hv = 9'($urandom_range(1, 12));
                end
                set_size(wv, hv, ($urandom_range(3) == 0));
            end

            case (kind)
                6:
                begin
                    // draws against an incomplete image, left unfinished
                    queue_sample(pick_fraction(), pick_fraction());
                    if (geo_w * geo_h > 1)
                    begin
                        queue_pixels(style, 0, $urandom_range(1, geo_w * geo_h - 1));
                        queue_sample(pick_fraction(), pick_fraction());
                    end
                end
                7:
                begin
                    // full image, then part of the next one, then the rest of it
                    queue_pixels(style, 0, geo_w * geo_h);
                    repeat ($urandom_range(1, 4))
                        queue_sample(pick_fraction(), pick_fraction());
                    extra = $urandom_range(1, geo_w * geo_h);
                    queue_pixels(shade_t'($urandom_range(4)), 0, extra);
                    queue_sample(pick_fraction(), pick_fraction());
                    if (extra < geo_w * geo_h)
                    begin
                        queue_pixels(style, extra, geo_w * geo_h - extra);
                        repeat ($urandom_range(1, 3))
                            queue_sample(pick_fraction(), pick_fraction());
                    end
                end
                8:
                begin
                    // two images back to back, only the second counts
                    queue_pixels(style, 0, geo_w * geo_h);
                    queue_pixels(shade_t'($urandom_range(4)), 0, geo_w * geo_h);
                    repeat ($urandom_range(1, 6))
                        queue_sample(pick_fraction(), pick_fraction());
                end
                default:
                begin
                    queue_pixels(style, 0, geo_w * geo_h);
                    n = $urandom_range(1, 6);
                    repeat (n)
                        queue_sample(pick_fraction(), pick_fraction());
                end
            endcase
        end

        settle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog against a block that stops answering
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
rtl/core/dics_pkg.sv
rtl/core/dics_ram.sv
rtl/core/dics_search.sv
rtl/core/density_inverse_cdf_sampler_core.sv
tb/sv/tb_density_inverse_cdf_sampler_core.sv
